>>> src/afs_pkg.sv
// Shared definitions for the arrive / flee steering pipeline.
// Holds the register map, reset values and the output saturation helper.
// No dependencies.
`default_nettype none

package afs_pkg;

   // Register map of the configuration port.
   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_MAX_ACCEL     = 3'd0;
   localparam csr_index_type CSR_MAX_SPEED     = 3'd1;
   localparam csr_index_type CSR_STOP_RADIUS   = 3'd2;
   localparam csr_index_type CSR_SLOW_RADIUS   = 3'd3;
   localparam csr_index_type CSR_RESPONSE_TIME = 3'd4;
   localparam csr_index_type CSR_FLEE_MODE     = 3'd5;

   // Values after reset, unsigned Q16.16.
   localparam logic [30:0] RST_MAX_ACCEL     = 31'd327680;
   localparam logic [30:0] RST_MAX_SPEED     = 31'd327680;
   localparam logic [30:0] RST_STOP_RADIUS   = 31'd0;
   localparam logic [30:0] RST_SLOW_RADIUS   = 31'd262144;
   localparam logic [30:0] RST_RESPONSE_TIME = 31'd6554;

   // Turns a sign and a 48-bit magnitude into a saturated 32-bit two's complement value.
   function automatic logic [31:0] sat_q16(input logic neg, input logic [47:0] mag);
      logic [31:0] r;
      if (!neg) begin
         r = (mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         r = (mag >= 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/afs_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side word along with each radicand. No package dependencies.
`default_nettype none

module afs_sqrt #(
   parameter int RW = 33,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);

   localparam int W = 2 * RW + 1;

   logic [RW:0]   vld_ff;
   logic [W-1:0]  op_ff  [RW];
   logic [W-1:0]  op_in  [RW];
   logic [W-1:0]  res_ff [RW+1];
   logic [W-1:0]  res_in [RW+1];
   logic [SW-1:0] side_ff [RW+1];

   // Each stage tries the next root bit and keeps the partial remainder.
   always_comb begin
      logic [W-1:0] one;
      logic [W-1:0] trial;
      logic         ge;
      op_in[0]  = W'(in_rad);
      res_in[0] = '0;
      for (int s = 1; s <= RW; s++) begin
         one   = W'(1) << (2 * (RW - s));
         trial = res_ff[s-1] + one;
         ge    = op_ff[s-1] >= trial;
         res_in[s] = ge ? ((res_ff[s-1] >> 1) + one) : (res_ff[s-1] >> 1);
         if (s < RW) begin
            op_in[s] = ge ? (op_ff[s-1] - trial) : op_ff[s-1];
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[RW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int s = 0; s < RW; s++) begin
            op_ff[s] <= op_in[s];
         end
         for (int s = 0; s <= RW; s++) begin
            res_ff[s] <= res_in[s];
         end
         for (int s = 1; s <= RW; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[RW];
   assign out_root  = res_ff[RW][RW-1:0];
   assign out_side  = side_ff[RW];

endmodule

`default_nettype wire

>>> src/afs_div.sv
// Pipelined restoring divider, one quotient bit per register stage, several
// lanes sharing one divisor. Carries a side word. No package dependencies.
`default_nettype none

module afs_div #(
   parameter int LN = 1,
   parameter int NW = 64,
   parameter int DW = 32,
   parameter int QW = 32,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num [LN],
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo [LN],
   output logic [SW-1:0] out_side
);

   // Wide enough for the remainder and for the divisor at its largest shift.
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [QW:0]   vld_ff;
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW+1];
   logic [CW-1:0] rem_ff  [QW][LN];
   logic [CW-1:0] rem_in  [QW][LN];
   logic [QW-1:0] quo_ff  [QW+1][LN];
   logic [QW-1:0] quo_in  [QW+1][LN];

   // Stage s decides quotient bit QW-s by one compare and subtract per lane.
   always_comb begin
      logic [CW-1:0] trial;
      logic          ge;
      for (int l = 0; l < LN; l++) begin
         rem_in[0][l] = CW'(in_num[l]);
         quo_in[0][l] = '0;
      end
      for (int s = 1; s <= QW; s++) begin
         trial = CW'(den_ff[s-1]) << (QW - s);
         for (int l = 0; l < LN; l++) begin
            ge = rem_ff[s-1][l] >= trial;
            quo_in[s][l] = {quo_ff[s-1][l][QW-2:0], ge};
            if (s < QW) begin
               rem_in[s][l] = ge ? (rem_ff[s-1][l] - trial) : rem_ff[s-1][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int s = 1; s < QW; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         for (int s = 1; s <= QW; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < LN; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
            end
         end
         for (int s = 0; s <= QW; s++) begin
            for (int l = 0; l < LN; l++) begin
               quo_ff[s][l] <= quo_in[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         out_quo[l] = quo_ff[QW][l];
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

`default_nettype wire

>>> src/arrive_flee_steering.sv
// Arrive / flee steering: one word in, one word out, one word per clock
// sustained while the output is not stalled. The pipeline depth is set by the
// two square root units and the four dividers, which retire one bit per stage.
// The whole pipeline advances together and holds while a finished result is stalled.
// The user must write configuration through the csr_ port while no word is in flight;
// the block does not enforce this. Uses afs_pkg, afs_sqrt and afs_div.
`default_nettype none

module arrive_flee_steering (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [31:0]     req_goal_x,
   input  logic signed [31:0]     req_goal_y,
   input  logic signed [31:0]     req_goal_z,
   input  logic signed [31:0]     req_pos_x,
   input  logic signed [31:0]     req_pos_y,
   input  logic signed [31:0]     req_pos_z,
   input  logic signed [31:0]     req_vel_x,
   input  logic signed [31:0]     req_vel_y,
   input  logic signed [31:0]     req_vel_z,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_accel_x,
   output logic signed [31:0]     rsp_accel_z,
   output logic                   rsp_arrived,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  afs_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);

   import afs_pkg::*;

   typedef struct packed {
      logic [2:0]        sgn;
      logic [2:0][32:0]  mag;
      logic [2:0][31:0]  vel;
   } geo_side_type;

   typedef struct packed {
      logic         arrived;
      logic         far;
      logic [32:0]  reach;
      geo_side_type geo;
   } spd_side_type;

   typedef struct packed {
      logic             arrived;
      logic             dist_zero;
      logic [2:0]       sgn;
      logic [2:0][31:0] vel;
   } vel_side_type;

   typedef struct packed {
      logic       arrived;
      logic [2:0] sgn;
   } err_side_type;

   typedef struct packed {
      logic             arrived;
      logic [2:0]       sgn;
      logic [2:0][47:0] mag;
   } acc_side_type;

   typedef struct packed {
      logic             arrived;
      logic             clip;
      logic [1:0]       sgn;
      logic [1:0][47:0] mag;
   } clip_side_type;

   // Configuration registers.
   logic [30:0] max_accel_ff;
   logic [30:0] max_speed_ff;
   logic [30:0] stop_radius_ff;
   logic [30:0] slow_radius_ff;
   logic [30:0] response_time_ff;
   logic        flee_ff;

   logic        adv;

   logic [31:0] goal [3];
   logic [31:0] pos  [3];
   logic [31:0] vel  [3];

   // Stage A: offset.
   logic        vld_a_ff;
   logic [32:0] d_a_ff   [3];
   logic [31:0] vel_a_ff [3];

   // Stage B: magnitudes and squares.
   logic         vld_b_ff;
   logic [32:0]  mag_b_in [3];
   logic [65:0]  sq_b_ff  [3];
   geo_side_type geo_b_ff;
   geo_side_type geo_b_in;

   // Stage C: sum of squares.
   logic         vld_c_ff;
   logic [65:0]  sum_c_ff;
   geo_side_type geo_c_ff;

   // Distance root.
   logic         sq1_vld;
   logic [32:0]  sq1_root;
   geo_side_type sq1_side;

   // Stage D: arrival test and slow-down numerator.
   logic         vld_d_ff;
   logic [61:0]  num2_d_ff [1];
   spd_side_type spd_d_ff;
   spd_side_type spd_d_in;

   // Speed divider.
   logic         dv2_vld;
   logic [30:0]  dv2_quo [1];
   spd_side_type dv2_side;

   // Stage E: desired velocity numerators.
   logic         vld_e_ff;
   logic [30:0]  ts_e;
   logic [63:0]  num3_e_ff [3];
   logic [32:0]  dist_e_ff;
   vel_side_type vel_e_ff;

   // Desired velocity divider.
   logic         dv3_vld;
   logic [30:0]  dv3_quo [3];
   vel_side_type dv3_side;

   // Stage G: velocity error.
   logic         vld_g_ff;
   logic [33:0]  e_g_in [3];
   logic [33:0]  e_g_ff [3];
   logic         arr_g_ff;
   logic [47:0]  num4_g [3];
   logic [33:0]  e_mag_g [3];
   err_side_type err_g;
   logic [30:0]  rt_g;

   // Response time divider.
   logic         dv4_vld;
   logic [47:0]  dv4_quo [3];
   err_side_type dv4_side;

   // Stages I, J, K: squared acceleration.
   logic         vld_i_ff;
   logic [47:0]  pp_hh_ff [3];
   logic [47:0]  pp_hl_ff [3];
   logic [47:0]  pp_ll_ff [3];
   acc_side_type acc_i_ff;
   logic         vld_j_ff;
   logic [95:0]  sq_j_ff [3];
   acc_side_type acc_j_ff;
   logic         vld_k_ff;
   logic [97:0]  sum_k_ff;
   acc_side_type acc_k_ff;

   // Acceleration magnitude root.
   logic         sq2_vld;
   logic [48:0]  sq2_root;
   acc_side_type sq2_side;

   // Stages L, M: clipping numerators.
   logic          vld_l_ff;
   logic [54:0]   plo_l_ff [2];
   logic [54:0]   phi_l_ff [2];
   logic [48:0]   m_l_ff;
   clip_side_type clp_l_ff;
   clip_side_type clp_l_in;
   logic          vld_m_ff;
   logic [78:0]   num6_m_ff [2];
   logic [48:0]   m_m_ff;
   clip_side_type clp_m_ff;

   // Clipping divider.
   logic          dv6_vld;
   logic [30:0]   dv6_quo [2];
   clip_side_type dv6_side;

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_accel_x_ff;
   logic [31:0] rsp_accel_z_ff;
   logic        rsp_arrived_ff;
   logic [47:0] out_mag [2];

   // The pipeline moves unless the output word is held by the consumer.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_accel_ff     <= RST_MAX_ACCEL;
         max_speed_ff     <= RST_MAX_SPEED;
         stop_radius_ff   <= RST_STOP_RADIUS;
         slow_radius_ff   <= RST_SLOW_RADIUS;
         response_time_ff <= RST_RESPONSE_TIME;
         flee_ff          <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_ACCEL:     max_accel_ff     <= csr_wdata[30:0];
            CSR_MAX_SPEED:     max_speed_ff     <= csr_wdata[30:0];
            CSR_STOP_RADIUS:   stop_radius_ff   <= csr_wdata[30:0];
            CSR_SLOW_RADIUS:   slow_radius_ff   <= csr_wdata[30:0];
            CSR_RESPONSE_TIME: response_time_ff <= csr_wdata[30:0];
            CSR_FLEE_MODE:     flee_ff          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign goal[0] = req_goal_x;
   assign goal[1] = req_goal_y;
   assign goal[2] = req_goal_z;
   assign pos[0]  = req_pos_x;
   assign pos[1]  = req_pos_y;
   assign pos[2]  = req_pos_z;
   assign vel[0]  = req_vel_x;
   assign vel[1]  = req_vel_y;
   assign vel[2]  = req_vel_z;

   // Valid bits of the glue stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff     <= 1'b0;
         vld_b_ff     <= 1'b0;
         vld_c_ff     <= 1'b0;
         vld_d_ff     <= 1'b0;
         vld_e_ff     <= 1'b0;
         vld_g_ff     <= 1'b0;
         vld_i_ff     <= 1'b0;
         vld_j_ff     <= 1'b0;
         vld_k_ff     <= 1'b0;
         vld_l_ff     <= 1'b0;
         vld_m_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff     <= req_valid;
         vld_b_ff     <= vld_a_ff;
         vld_c_ff     <= vld_b_ff;
         vld_d_ff     <= sq1_vld;
         vld_e_ff     <= dv2_vld;
         vld_g_ff     <= dv3_vld;
         vld_i_ff     <= dv4_vld;
         vld_j_ff     <= vld_i_ff;
         vld_k_ff     <= vld_j_ff;
         vld_l_ff     <= sq2_vld;
         vld_m_ff     <= vld_l_ff;
         rsp_valid_ff <= dv6_vld;
      end
   end

   // Stage A: offset toward the goal, or away from it when fleeing.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d_a_ff[i] <= flee_ff ? ({pos[i][31], pos[i]} - {goal[i][31], goal[i]})
                                 : ({goal[i][31], goal[i]} - {pos[i][31], pos[i]});
            vel_a_ff[i] <= vel[i];
         end
      end
   end

   // Stage B: component magnitudes and their squares.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_b_in[i]     = d_a_ff[i][32] ? (33'd0 - d_a_ff[i]) : d_a_ff[i];
         geo_b_in.sgn[i] = d_a_ff[i][32];
         geo_b_in.mag[i] = mag_b_in[i];
         geo_b_in.vel[i] = vel_a_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_b_ff[i] <= 66'(mag_b_in[i]) * 66'(mag_b_in[i]);
         end
         geo_b_ff <= geo_b_in;
      end
   end

   // Stage C: squared distance.
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_c_ff <= sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
         geo_c_ff <= geo_b_ff;
      end
   end

   afs_sqrt #(
      .RW (33),
      .SW ($bits(geo_side_type))
   ) u_dist_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_c_ff),
      .in_rad    (sum_c_ff),
      .in_side   (geo_c_ff),
      .out_valid (sq1_vld),
      .out_root  (sq1_root),
      .out_side  (sq1_side)
   );

   // Stage D: arrival test and the scaled speed numerator inside the slow radius.
   always_comb begin
      spd_d_in.arrived = !flee_ff && (sq1_root < 33'(stop_radius_ff));
      spd_d_in.far     = sq1_root > 33'(slow_radius_ff);
      spd_d_in.reach   = sq1_root;
      spd_d_in.geo     = sq1_side;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num2_d_ff[0] <= 62'(max_speed_ff) * 62'(sq1_root[30:0]);
         spd_d_ff     <= spd_d_in;
      end
   end

   afs_div #(
      .LN (1),
      .NW (62),
      .DW (31),
      .QW (31),
      .SW ($bits(spd_side_type))
   ) u_speed_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_d_ff),
      .in_num    (num2_d_ff),
      .in_den    (slow_radius_ff),
      .in_side   (spd_d_ff),
      .out_valid (dv2_vld),
      .out_quo   (dv2_quo),
      .out_side  (dv2_side)
   );

   // Stage E: target speed times each offset component.
   assign ts_e = dv2_side.far ? max_speed_ff : dv2_quo[0];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            num3_e_ff[i] <= 64'(dv2_side.geo.mag[i]) * 64'(ts_e);
         end
         dist_e_ff          <= dv2_side.reach;
         vel_e_ff.arrived   <= dv2_side.arrived;
         vel_e_ff.dist_zero <= (dv2_side.reach == '0);
         vel_e_ff.sgn       <= dv2_side.geo.sgn;
         vel_e_ff.vel       <= dv2_side.geo.vel;
      end
   end

   afs_div #(
      .LN (3),
      .NW (64),
      .DW (33),
      .QW (31),
      .SW ($bits(vel_side_type))
   ) u_desired_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_e_ff),
      .in_num    (num3_e_ff),
      .in_den    (dist_e_ff),
      .in_side   (vel_e_ff),
      .out_valid (dv3_vld),
      .out_quo   (dv3_quo),
      .out_side  (dv3_side)
   );

   // Stage G: velocity error, desired minus current.
   always_comb begin
      logic [32:0] want;
      for (int i = 0; i < 3; i++) begin
         if (dv3_side.dist_zero) begin
            want = '0;
         end else if (dv3_side.sgn[i]) begin
            want = 33'd0 - 33'(dv3_quo[i]);
         end else begin
            want = 33'(dv3_quo[i]);
         end
         e_g_in[i] = {want[32], want} - {{2{dv3_side.vel[i][31]}}, dv3_side.vel[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e_g_ff[i] <= e_g_in[i];
         end
         arr_g_ff <= dv3_side.arrived;
      end
   end

   // Error magnitude in Q16.16 scaled up by one unit of time.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_mag_g[i]   = e_g_ff[i][33] ? (34'd0 - e_g_ff[i]) : e_g_ff[i];
         num4_g[i]    = {e_mag_g[i][31:0], 16'h0000};
         err_g.sgn[i] = e_g_ff[i][33];
      end
      err_g.arrived = arr_g_ff;
   end

   // A zero response time acts as the smallest step.
   assign rt_g = (response_time_ff == '0) ? 31'd1 : response_time_ff;

   afs_div #(
      .LN (3),
      .NW (48),
      .DW (31),
      .QW (48),
      .SW ($bits(err_side_type))
   ) u_response_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_g_ff),
      .in_num    (num4_g),
      .in_den    (rt_g),
      .in_side   (err_g),
      .out_valid (dv4_vld),
      .out_quo   (dv4_quo),
      .out_side  (dv4_side)
   );

   // Stage I: squares of the 48-bit magnitudes as partial products of 24-bit halves.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pp_hh_ff[i]     <= 48'(dv4_quo[i][47:24]) * 48'(dv4_quo[i][47:24]);
            pp_hl_ff[i]     <= 48'(dv4_quo[i][47:24]) * 48'(dv4_quo[i][23:0]);
            pp_ll_ff[i]     <= 48'(dv4_quo[i][23:0]) * 48'(dv4_quo[i][23:0]);
            acc_i_ff.mag[i] <= dv4_quo[i];
         end
         acc_i_ff.sgn     <= dv4_side.sgn;
         acc_i_ff.arrived <= dv4_side.arrived;
      end
   end

   // Stage J: recombine the partial products.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_j_ff[i] <= (96'(pp_hh_ff[i]) << 48) + (96'(pp_hl_ff[i]) << 25)
                          + 96'(pp_ll_ff[i]);
         end
         acc_j_ff <= acc_i_ff;
      end
   end

   // Stage K: squared acceleration magnitude.
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_k_ff <= 98'(sq_j_ff[0]) + 98'(sq_j_ff[1]) + 98'(sq_j_ff[2]);
         acc_k_ff <= acc_j_ff;
      end
   end

   afs_sqrt #(
      .RW (49),
      .SW ($bits(acc_side_type))
   ) u_accel_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_k_ff),
      .in_rad    (sum_k_ff),
      .in_side   (acc_k_ff),
      .out_valid (sq2_vld),
      .out_root  (sq2_root),
      .out_side  (sq2_side)
   );

   // Stage L: clip decision and max_accel partial products for x and z.
   always_comb begin
      clp_l_in.arrived = sq2_side.arrived;
      clp_l_in.clip    = sq2_root > 49'(max_accel_ff);
      clp_l_in.sgn[0]  = sq2_side.sgn[0];
      clp_l_in.sgn[1]  = sq2_side.sgn[2];
      clp_l_in.mag[0]  = sq2_side.mag[0];
      clp_l_in.mag[1]  = sq2_side.mag[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 2; i++) begin
            plo_l_ff[i] <= 55'(clp_l_in.mag[i][23:0]) * 55'(max_accel_ff);
            phi_l_ff[i] <= 55'(clp_l_in.mag[i][47:24]) * 55'(max_accel_ff);
         end
         m_l_ff   <= sq2_root;
         clp_l_ff <= clp_l_in;
      end
   end

   // Stage M: full product of magnitude and max_accel.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 2; i++) begin
            num6_m_ff[i] <= (79'(phi_l_ff[i]) << 24) + 79'(plo_l_ff[i]);
         end
         m_m_ff   <= m_l_ff;
         clp_m_ff <= clp_l_ff;
      end
   end

   afs_div #(
      .LN (2),
      .NW (79),
      .DW (49),
      .QW (31),
      .SW ($bits(clip_side_type))
   ) u_clip_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_m_ff),
      .in_num    (num6_m_ff),
      .in_den    (m_m_ff),
      .in_side   (clp_m_ff),
      .out_valid (dv6_vld),
      .out_quo   (dv6_quo),
      .out_side  (dv6_side)
   );

   // Output word: clipped or raw magnitude, saturated; zero on arrival.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         out_mag[i] = dv6_side.clip ? 48'(dv6_quo[i]) : dv6_side.mag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_arrived_ff <= dv6_side.arrived;
         if (dv6_side.arrived) begin
            rsp_accel_x_ff <= '0;
            rsp_accel_z_ff <= '0;
         end else begin
            rsp_accel_x_ff <= sat_q16(dv6_side.sgn[0], out_mag[0]);
            rsp_accel_z_ff <= sat_q16(dv6_side.sgn[1], out_mag[1]);
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_accel_x = rsp_accel_x_ff;
   assign rsp_accel_z = rsp_accel_z_ff;
   assign rsp_arrived = rsp_arrived_ff;

   // An arrived word never carries acceleration.
   a_arrive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived |-> (rsp_accel_x == '0) && (rsp_accel_z == '0))
      else $error("arrived word with nonzero acceleration");

   // Flee mode never reports arrival.
   a_flee_no_arrive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && flee_ff |-> !rsp_arrived)
      else $error("arrival reported in flee mode");

   // A held output word keeps the valid bits of stages A and M frozen.
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_m_ff) && $stable(vld_a_ff))
      else $error("pipeline moved while output was held");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking bench for the arrive / flee steering pipeline.
// Predicts each result in fixed point and compares it with the block's output.
// Depends on afs_pkg and arrive_flee_steering.
`timescale 1ns / 1ps

module testbench;
   import afs_pkg::*;

   localparam csr_index_type CSR_SPARE_LOW  = 3'd6;
   localparam csr_index_type CSR_SPARE_HIGH = 3'd7;
   localparam int PIPE_DEPTH  = 241;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [63:0] STEP_CAP = 64'h4000_0000_0000_0000;

   typedef struct {
      logic signed [31:0] goal_x, goal_y, goal_z;
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] vel_x, vel_y, vel_z;
   } query_type;

   typedef struct {
      logic signed [31:0] accel_x, accel_z;
      logic               arrived;
   } steer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_goal_x = '0, req_goal_y = '0, req_goal_z = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [31:0] rsp_accel_x, rsp_accel_z;
   logic rsp_arrived;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_MAX_ACCEL;
   logic [31:0] csr_wdata = '0;

   // Shadow copy of the register file.
   logic [30:0] max_accel_q, max_speed_q, stop_radius_q, slow_radius_q, resp_time_q;
   logic        flee_q;

   steer_type steer_queue[$];
   int mismatches = 0;
   int cycles = 0;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;

   arrive_flee_steering uut (.*);

   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver stalls: random, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] abs64(longint v);
      logic [63:0] u;
      u = 64'(v);
      return (v < 0) ? -u : u;
   endfunction

   // trunc(v * k / dv) toward zero, quotient kept to 64 bits and capped at 2^62.
   function automatic longint scale_div(longint v, logic [63:0] k, logic [63:0] dv);
      logic [127:0] q;
      logic [63:0]  ql;
      q  = ({64'd0, abs64(v)} * {64'd0, k}) / {64'd0, dv};
      ql = q[63:0];
      if (ql > STEP_CAP) ql = STEP_CAP;
      return (v < 0) ? -longint'(ql) : longint'(ql);
   endfunction

   function automatic logic [127:0] norm_sq(longint a, longint b, longint c);
      return {64'd0, abs64(a)} * {64'd0, abs64(a)} + {64'd0, abs64(b)} * {64'd0, abs64(b)}
           + {64'd0, abs64(c)} * {64'd0, abs64(c)};
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic steer_type predict_steer(query_type q);
      longint d[3], a[3], vel[3], want;
      logic [63:0] reach, ts, rt, m;
      steer_type s;
      vel[0] = q.vel_x; vel[1] = q.vel_y; vel[2] = q.vel_z;
      d[0] = longint'(q.goal_x) - longint'(q.pos_x);
      d[1] = longint'(q.goal_y) - longint'(q.pos_y);
      d[2] = longint'(q.goal_z) - longint'(q.pos_z);
      if (flee_q) for (int i = 0; i < 3; i++) d[i] = -d[i];
      reach = isqrt(norm_sq(d[0], d[1], d[2]));
      if (!flee_q && reach < {33'd0, stop_radius_q}) begin
         s.accel_x = '0; s.accel_z = '0; s.arrived = 1'b1;
         return s;
      end
      if (reach > {33'd0, slow_radius_q}) ts = {33'd0, max_speed_q};
      else if (slow_radius_q == 0) ts = '0;
      else ts = ({33'd0, max_speed_q} * reach) / {33'd0, slow_radius_q};
      rt = (resp_time_q == 0) ? 64'd1 : {33'd0, resp_time_q};
      for (int i = 0; i < 3; i++) begin
         want = (reach != 0) ? scale_div(d[i], ts, reach) : 0;
         a[i] = scale_div(want - vel[i], 64'd65536, rt);
      end
      m = isqrt(norm_sq(a[0], a[1], a[2]));
      if (m > {33'd0, max_accel_q})
         for (int i = 0; i < 3; i++) a[i] = scale_div(a[i], {33'd0, max_accel_q}, m);
      s.accel_x = clip32(a[0]);
      s.accel_z = clip32(a[2]);
      s.arrived = 1'b0;
      return s;
   endfunction

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      steer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (steer_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word at cycle %0d", cycles);
         end else begin
            e = steer_queue.pop_front();
            if (rsp_accel_x !== e.accel_x || rsp_accel_z !== e.accel_z ||
                rsp_arrived !== e.arrived) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected x=%0d z=%0d arr=%0b, got x=%0d z=%0d arr=%0b",
                           e.accel_x, e.accel_z, e.arrived,
                           rsp_accel_x, rsp_accel_z, rsp_arrived);
            end
         end
      end
   end

   // Send one query word, with a random gap first; valid stays up between words.
   task automatic send_query(query_type q);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_goal_x <= q.goal_x; req_goal_y <= q.goal_y; req_goal_z <= q.goal_z;
      req_pos_x  <= q.pos_x;  req_pos_y  <= q.pos_y;  req_pos_z  <= q.pos_z;
      req_vel_x  <= q.vel_x;  req_vel_y  <= q.vel_y;  req_vel_z  <= q.vel_z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      steer_queue.push_back(predict_steer(q));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (steer_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_ACCEL:     max_accel_q   = value[30:0];
         CSR_MAX_SPEED:     max_speed_q   = value[30:0];
         CSR_STOP_RADIUS:   stop_radius_q = value[30:0];
         CSR_SLOW_RADIUS:   slow_radius_q = value[30:0];
         CSR_RESPONSE_TIME: resp_time_q   = value[30:0];
         CSR_FLEE_MODE:     flee_q        = value[0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [31:0] acc, logic [31:0] spd, logic [31:0] stp,
                            logic [31:0] slw, logic [31:0] rsp, logic [31:0] fle);
      write_csr(CSR_MAX_ACCEL, acc);
      write_csr(CSR_MAX_SPEED, spd);
      write_csr(CSR_STOP_RADIUS, stp);
      write_csr(CSR_SLOW_RADIUS, slw);
      write_csr(CSR_RESPONSE_TIME, rsp);
      write_csr(CSR_FLEE_MODE, fle);
   endtask

   // Coordinate: full range, near a base point, or an extreme.
   function automatic logic signed [31:0] rand_coord(logic signed [31:0] base);
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3:       return base;
         4, 5, 6: return base + $signed($urandom_range(8191) - 4096);
         default: return base + $signed($urandom_range(2097151) - 1048576);
      endcase
   endfunction

   function automatic query_type rand_query();
      query_type q;
      logic signed [31:0] b;
      b = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(2097151) - 1048576);
      q.goal_x = rand_coord(b); q.goal_y = rand_coord(b); q.goal_z = rand_coord(b);
      q.pos_x  = rand_coord(q.goal_x); q.pos_y = rand_coord(q.goal_y);
      q.pos_z  = rand_coord(q.goal_z);
      q.vel_x  = rand_coord(0); q.vel_y = rand_coord(0); q.vel_z = rand_coord(0);
      return q;
   endfunction

   function automatic query_type make_query(logic signed [31:0] g, logic signed [31:0] p,
                                            logic signed [31:0] v);
      query_type q;
      q.goal_x = g; q.goal_y = g; q.goal_z = g;
      q.pos_x = p;  q.pos_y = p;  q.pos_z = p;
      q.vel_x = v;  q.vel_y = -v; q.vel_z = v;
      return q;
   endfunction

   // Directed words: zero offset, field extremes, arrival, flee and odd registers.
   task automatic test_directed();
      query_type q;
      send_query(make_query(0, 0, 0));
      send_query(make_query(32'h0001_0000, 32'h0001_0000, 32'h0002_0000));
      send_query(make_query(32'h7FFF_FFFF, 32'h8000_0000, 0));
      send_query(make_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_query(make_query(32'h0000_8000, 0, 32'h8000_0000));
      send_query(make_query(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
      q = make_query(32'h0003_0000, 0, 0);
      q.goal_y = 0; q.goal_z = 32'hFFFD_0000;
      send_query(q);
      send_query(make_query(32'h0010_0000, 0, 32'h0001_0000));
      drain_pipe();
      // Arrival inside a stop radius, then flee from one of the same points and from a zero offset.
      write_csr(CSR_STOP_RADIUS, 32'h0002_0000);
      send_query(make_query(32'h0000_8000, 0, 32'h0004_0000));
      send_query(make_query(0, 0, 32'h0004_0000));
      send_query(make_query(32'h0004_0000, 0, 0));
      drain_pipe();
      write_csr(CSR_FLEE_MODE, 32'h0000_0001);
      send_query(make_query(32'h0000_8000, 0, 32'h0004_0000));
      send_query(make_query(0, 0, 0));
      drain_pipe();
      // Zero slow radius and zero response time, and ignored spare indexes.
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
      write_csr(CSR_SPARE_LOW, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE_HIGH, 32'h0000_0000);
      send_query(make_query(0, 0, 32'h0000_0001));
      send_query(make_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      send_query(make_query(32'h0000_0001, 0, 0));
      send_query(make_query(32'h0001_0000, 0, 32'h7FFF_FFFF));
      drain_pipe();
      write_all(0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
      send_query(make_query(32'h1234_5678, 32'hEDCB_A987, 32'h0001_0000));
      send_query(make_query(0, 32'h0000_0010, 32'h8000_0000));
      drain_pipe();
   endtask

   // One phase of random words under one register setting and one idling mode.
   task automatic run_phase(int count, int idle, int stall);
      sender_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) send_query(rand_query());
      drain_pipe();
   endtask

   task automatic test_register_sweep();
      write_all(RST_MAX_ACCEL, RST_MAX_SPEED, RST_STOP_RADIUS, RST_SLOW_RADIUS,
                RST_RESPONSE_TIME, 0);
      run_phase(150, 0, 0);
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 1);
      run_phase(150, 62, 0);
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0008_0000, 32'h7FFF_FFFF, 1, 0);
      run_phase(150, 0, 62);
      write_all(0, 0, 0, 0, 0, 0);
      run_phase(150, 10, 10);
      write_all(32'h0100_0000, 32'h0040_0000, 32'h0000_4000, 32'h0010_0000, 32'h0001_0000, 1);
      run_phase(150, 0, 0);
      for (int p = 0; p < 4; p++) begin
         write_all($urandom, $urandom, $urandom_range(1) ? $urandom : $urandom_range(1 << 22),
                   $urandom_range(1) ? $urandom : $urandom_range(1 << 22), $urandom,
                   $urandom);
         run_phase(150, (p % 2) ? 62 : 10, (p < 2) ? 62 : 10);
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_backpressure();
      write_all(RST_MAX_ACCEL, RST_MAX_SPEED, 32'h0001_0000, RST_SLOW_RADIUS,
                RST_RESPONSE_TIME, 0);
      sender_idle_pct = 0;
      stall_pct = 0;
      hold_left <= 2 * PIPE_DEPTH + 100;
      for (int i = 0; i < 300; i++) send_query(rand_query());
      drain_pipe();
   endtask

   initial begin
      max_accel_q = RST_MAX_ACCEL; max_speed_q = RST_MAX_SPEED;
      stop_radius_q = RST_STOP_RADIUS; slow_radius_q = RST_SLOW_RADIUS;
      resp_time_q = RST_RESPONSE_TIME; flee_q = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_sweep();
      test_backpressure();
      if (mismatches == 0 && steer_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
src/afs_pkg.sv
src/afs_sqrt.sv
src/afs_div.sv
src/arrive_flee_steering.sv
verif/testbench.sv
